@@ rtl/qrs_pkg.sv @@
// shared types and constants for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;

    localparam logic [2:0] CASE_INFINITE   = 3'd0;
    localparam logic [2:0] CASE_CONTRA     = 3'd1;
    localparam logic [2:0] CASE_LINEAR     = 3'd2;
    localparam logic [2:0] CASE_NEG_DISC   = 3'd3;
    localparam logic [2:0] CASE_DOUBLE     = 3'd4;
    localparam logic [2:0] CASE_TWO        = 3'd5;

    typedef struct packed {
        logic signed [WORD_W-1:0] coef_a;
        logic signed [WORD_W-1:0] coef_b;
        logic signed [WORD_W-1:0] coef_c;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]               case_code;
        logic signed [WORD_W-1:0] root_one;
        logic signed [WORD_W-1:0] root_two;
        logic                     saturated;
    } out_beat_t;

endpackage
`default_nettype wire

@@ rtl/quadratic_root_solver.sv @@
// quadratic root solver top level: classify, square root chain, divider chains
// pipeline: 107 register stages from the input registers to out_valid:
//          3 front stages + 51 square root cells + 52 divider cells + 1 output register
// throughput: one beat per cycle; every stage is a register row that advances together,
//             held only while a result waits in the output register
// reset: rst_n clears the valid bits of every stage and the output; data regs keep no reset
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire qrs_pkg::in_beat_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output qrs_pkg::out_beat_t       out_data
);
    localparam int W     = qrs_pkg::WORD_W;
    localparam int F     = qrs_pkg::FRAC_W;
    localparam int MW    = W + 1;            // magnitude of a word, incl. -2^(W-1)
    localparam int DSW   = 2*MW + 3;         // discriminant magnitude width
    localparam int XW    = DSW + 2*F;        // square root radicand
    localparam int RW    = (XW + 1) / 2;     // square root width
    localparam int NUM_W = ((RW > MW + F) ? RW : (MW + F)) + 1;
    localparam int DENW  = MW + 1;
    localparam int SQ_N  = RW;
    localparam int DV_N  = NUM_W;

    // pipeline advance: whole chain moves when the output slot can take a beat
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------- stage 1: magnitudes and signs ----------
    logic          s1_v_reg;
    logic          na1_reg, nb1_reg, nc1_reg;
    logic [MW-1:0] ma1_reg, mb1_reg, mc1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_v_reg <= 1'b0;
        else if (adv) s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na1_reg <= in_data.coef_a[W-1];
            nb1_reg <= in_data.coef_b[W-1];
            nc1_reg <= in_data.coef_c[W-1];
            ma1_reg <= in_data.coef_a[W-1] ? (MW'(0) - MW'(in_data.coef_a)) : MW'(in_data.coef_a);
            mb1_reg <= in_data.coef_b[W-1] ? (MW'(0) - MW'(in_data.coef_b)) : MW'(in_data.coef_b);
            mc1_reg <= in_data.coef_c[W-1] ? (MW'(0) - MW'(in_data.coef_c)) : MW'(in_data.coef_c);
        end
    end

    // ---------- stage 2: products (one multiplier each) ----------
    logic            s2_v_reg;
    logic            na2_reg, nb2_reg, fneg2_reg;
    logic [MW-1:0]   ma2_reg, mb2_reg, mc2_reg;
    logic [2*MW-1:0] bsq2_reg, ac2_reg;
    logic [2:0]      code2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_v_reg <= 1'b0;
        else if (adv) s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na2_reg   <= na1_reg;
            nb2_reg   <= nb1_reg;
            fneg2_reg <= !(na1_reg ^ nc1_reg);
            ma2_reg   <= ma1_reg;
            mb2_reg   <= mb1_reg;
            mc2_reg   <= mc1_reg;
            bsq2_reg  <= (2*MW)'(mb1_reg) * (2*MW)'(mb1_reg);
            ac2_reg   <= (2*MW)'(ma1_reg) * (2*MW)'(mc1_reg);
            if (ma1_reg == '0 && mb1_reg == '0 && mc1_reg == '0)
                code2_reg <= qrs_pkg::CASE_INFINITE;
            else if (ma1_reg == '0 && mb1_reg == '0)
                code2_reg <= qrs_pkg::CASE_CONTRA;
            else if (ma1_reg == '0)
                code2_reg <= qrs_pkg::CASE_LINEAR;
            else
                code2_reg <= qrs_pkg::CASE_TWO;
        end
    end

    // ---------- stage 3: discriminant, case, numerators ----------
    logic           s3_v_reg;
    logic [2:0]     code3_reg;
    logic [XW-1:0]  x3_reg;
    logic           nb3_reg, na3_reg;
    logic [MW+F-1:0] bterm3_reg;
    logic [DENW-1:0] den3_reg;

    logic [DSW-1:0] bsq_w, fac_w, disc_w;
    logic           disc_neg;
    logic [2:0]     code_w;

    always_comb
    begin
        bsq_w = DSW'(bsq2_reg);
        fac_w = DSW'(ac2_reg) << 2;
        if (!fneg2_reg)
        begin
            disc_w   = bsq_w + fac_w;
            disc_neg = 1'b0;
        end
        else if (bsq_w >= fac_w)
        begin
            disc_w   = bsq_w - fac_w;
            disc_neg = 1'b0;
        end
        else
        begin
            disc_w   = fac_w - bsq_w;
            disc_neg = 1'b1;
        end
        code_w = code2_reg;
        if (code2_reg == qrs_pkg::CASE_TWO)
        begin
            if (disc_neg)           code_w = qrs_pkg::CASE_NEG_DISC;
            else if (disc_w == '0)  code_w = qrs_pkg::CASE_DOUBLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_v_reg <= 1'b0;
        else if (adv) s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code3_reg <= code_w;
            x3_reg    <= XW'(disc_w) << (2*F);
            // linear case divides c by b, otherwise b by 2a
            if (code2_reg == qrs_pkg::CASE_LINEAR)
            begin
                bterm3_reg <= (MW+F)'(mc2_reg) << F;
                den3_reg   <= DENW'(mb2_reg);
                // sign of -c/b
                nb3_reg    <= !(fneg2_reg ^ na2_reg) ^ nb2_reg ^ 1'b1;
                na3_reg    <= 1'b0;
            end
            else
            begin
                bterm3_reg <= (MW+F)'(mb2_reg) << F;
                den3_reg   <= DENW'(ma2_reg) << 1;
                nb3_reg    <= nb2_reg;
                na3_reg    <= na2_reg;
            end
        end
    end

    // ---------- square root chain, with side data carried along ----------
    typedef struct packed {
        logic [2:0]      code;
        logic            na;
        logic            nb;
        logic [MW+F-1:0] bterm;
        logic [DENW-1:0] den;
    } side_t;

    logic [XW-1:0] sx   [SQ_N+1];
    logic [RW-1:0] sr   [SQ_N+1];
    logic          sv   [SQ_N+1];
    side_t         sd   [SQ_N+1];

    assign sx[0] = x3_reg;
    assign sr[0] = '0;
    assign sv[0] = s3_v_reg;
    assign sd[0] = '{code: code3_reg, na: na3_reg, nb: nb3_reg,
                     bterm: bterm3_reg, den: den3_reg};

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        logic [XW-1:0] xo;
        logic [RW-1:0] ro;
        logic          v_reg;
        side_t         sd_reg;
        // cells carry data unconditionally; a stall holds via adv mux
        qrs_sqrt_cell #(.XW(XW), .RW(RW), .POS(SQ_N-1-i)) u_cell (
            .clk   (clk),
            .x_in  (adv ? sx[i] : sx[i+1]),
            .r_in  (adv ? sr[i] : sr[i+1]),
            .x_out (xo),
            .r_out (ro)
        );
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg <= 1'b0;
            else if (adv) v_reg <= sv[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                sd_reg <= sd[i];
        end
        assign sx[i+1] = xo;
        assign sr[i+1] = ro;
        assign sv[i+1] = v_reg;
        assign sd[i+1] = sd_reg;
    end

    // ---------- numerators for the two roots ----------
    logic [NUM_W-1:0] bt_w, rt_w, n1_w, n2_w;
    logic             n1neg, n2neg, sgn1_w, sgn2_w;
    side_t            sq_end;

    always_comb
    begin
        sq_end = sd[SQ_N];
        bt_w   = NUM_W'(sq_end.bterm);
        rt_w   = (sq_end.code == qrs_pkg::CASE_TWO) ? NUM_W'(sr[SQ_N]) : '0;
        // -b + r, with -b of sign !nb
        if (!sq_end.nb)
        begin
            // -b negative
            if (bt_w >= rt_w) begin n1_w = bt_w - rt_w; n1neg = (bt_w != rt_w) ? 1'b1 : 1'b0; end
            else              begin n1_w = rt_w - bt_w; n1neg = 1'b0; end
            n2_w  = bt_w + rt_w;
            n2neg = 1'b1;
        end
        else
        begin
            n1_w  = bt_w + rt_w;
            n1neg = 1'b0;
            if (bt_w >= rt_w) begin n2_w = bt_w - rt_w; n2neg = 1'b0; end
            else              begin n2_w = rt_w - bt_w; n2neg = 1'b1; end
        end
        if (sq_end.code == qrs_pkg::CASE_LINEAR)
        begin
            sgn1_w = sq_end.nb;   // sign prepared in stage 3
            sgn2_w = 1'b0;
        end
        else
        begin
            sgn1_w = n1neg ^ sq_end.na;
            sgn2_w = n2neg ^ sq_end.na;
        end
    end

    // equal magnitudes in the n1 sum give a nonnegative n1; n1sign_fix passes sgn1_w on unchanged
    logic n1sign_fix;
    assign n1sign_fix = sgn1_w;

    // ---------- divider chains (two in parallel) ----------
    typedef struct packed {
        logic [2:0] code;
        logic       s1;
        logic       s2;
    } dside_t;

    logic [NUM_W-1:0] r1 [DV_N+1];
    logic [NUM_W-1:0] q1 [DV_N+1];
    logic [NUM_W-1:0] r2 [DV_N+1];
    logic [NUM_W-1:0] q2 [DV_N+1];
    logic [DENW-1:0]  d1 [DV_N+1];
    logic [DENW-1:0]  d2 [DV_N+1];
    logic             dv [DV_N+1];
    dside_t           ds [DV_N+1];

    assign r1[0] = n1_w;
    assign r2[0] = n2_w;
    assign q1[0] = '0;
    assign q2[0] = '0;
    assign d1[0] = sq_end.den;
    assign d2[0] = sq_end.den;
    assign dv[0] = sv[SQ_N];
    assign ds[0] = '{code: sq_end.code, s1: n1sign_fix, s2: sgn2_w};

    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        logic [NUM_W-1:0] r1o, q1o, r2o, q2o;
        logic [DENW-1:0]  d1o, d2o;
        logic             v_reg;
        dside_t           ds_reg;
        qrs_div_cell #(.NW(NUM_W), .DW(DENW), .POS(DV_N-1-j)) u_div1 (
            .clk     (clk),
            .rem_in  (adv ? r1[j] : r1[j+1]),
            .den_in  (adv ? d1[j] : d1[j+1]),
            .q_in    (adv ? q1[j] : q1[j+1]),
            .rem_out (r1o),
            .den_out (d1o),
            .q_out   (q1o)
        );
        qrs_div_cell #(.NW(NUM_W), .DW(DENW), .POS(DV_N-1-j)) u_div2 (
            .clk     (clk),
            .rem_in  (adv ? r2[j] : r2[j+1]),
            .den_in  (adv ? d2[j] : d2[j+1]),
            .q_in    (adv ? q2[j] : q2[j+1]),
            .rem_out (r2o),
            .den_out (d2o),
            .q_out   (q2o)
        );
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg <= 1'b0;
            else if (adv) v_reg <= dv[j];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                ds_reg <= ds[j];
        end
        assign r1[j+1] = r1o;
        assign q1[j+1] = q1o;
        assign r2[j+1] = r2o;
        assign q2[j+1] = q2o;
        assign d1[j+1] = d1o;
        assign d2[j+1] = d2o;
        assign dv[j+1] = v_reg;
        assign ds[j+1] = ds_reg;
    end

    // ---------- clamp, sign and output register ----------
    localparam logic [NUM_W-1:0] POS_MAX = (NUM_W'(1) << (W-1)) - NUM_W'(1);
    localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(1) << (W-1);

    logic [W-1:0] root1_w, root2_w;
    logic         sat1_w, sat2_w;
    dside_t       dv_end;

    always_comb
    begin
        logic [NUM_W-1:0] qa, qb;
        dv_end = ds[DV_N];
        qa = q1[DV_N];
        qb = q2[DV_N];
        sat1_w = 1'b0;
        sat2_w = 1'b0;
        if (!dv_end.s1)
        begin
            if (qa > POS_MAX) begin qa = POS_MAX; sat1_w = 1'b1; end
            root1_w = W'(qa);
        end
        else
        begin
            if (qa > NEG_MAX) begin qa = NEG_MAX; sat1_w = 1'b1; end
            root1_w = W'(NUM_W'(0) - qa);
        end
        if (!dv_end.s2)
        begin
            if (qb > POS_MAX) begin qb = POS_MAX; sat2_w = 1'b1; end
            root2_w = W'(qb);
        end
        else
        begin
            if (qb > NEG_MAX) begin qb = NEG_MAX; sat2_w = 1'b1; end
            root2_w = W'(NUM_W'(0) - qb);
        end
    end

    logic out_v_reg;
    qrs_pkg::out_beat_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= dv[DV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.case_code <= dv_end.code;
            case (dv_end.code)
                qrs_pkg::CASE_LINEAR:
                begin
                    out_reg.root_one  <= root1_w;
                    out_reg.root_two  <= '0;
                    out_reg.saturated <= sat1_w;
                end
                qrs_pkg::CASE_DOUBLE:
                begin
                    out_reg.root_one  <= root1_w;
                    out_reg.root_two  <= root1_w;
                    out_reg.saturated <= sat1_w;
                end
                qrs_pkg::CASE_TWO:
                begin
                    out_reg.root_one  <= root1_w;
                    out_reg.root_two  <= root2_w;
                    out_reg.saturated <= sat1_w | sat2_w;
                end
                default:
                begin
                    out_reg.root_one  <= '0;
                    out_reg.root_two  <= '0;
                    out_reg.saturated <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

@@ rtl/qrs_sqrt_cell.sv @@
// one stage of the restoring integer square root chain
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell #(
    parameter int XW  = 130,
    parameter int RW  = 65,
    parameter int POS = 0
) (
    input  wire logic          clk,
    input  wire logic [XW-1:0] x_in,
    input  wire logic [RW-1:0] r_in,
    output logic      [XW-1:0] x_out,
    output logic      [RW-1:0] r_out
);
    logic [XW-1:0] bit_w;
    logic [XW-1:0] trial;
    logic [XW-1:0] r_wide;
    logic          take;

    // trial subtract of (r << (pos + 1)) | (1 << 2*pos), with r kept as result bits so far
    always_comb
    begin
        bit_w  = '0;
        bit_w[2*POS] = 1'b1;
        r_wide = XW'(r_in) << (POS + 1);
        trial  = r_wide | bit_w;
        take   = (x_in >= trial);
    end

    always_ff @(posedge clk)
    begin
        x_out <= take ? (x_in - trial) : x_in;
        r_out <= take ? (r_in | (RW'(1) << POS)) : r_in;
    end
endmodule
`default_nettype wire

@@ rtl/qrs_div_cell.sv @@
// one stage of the restoring divider chain, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell #(
    parameter int NW  = 100,
    parameter int DW  = 34,
    parameter int POS = 0
) (
    input  wire logic          clk,
    input  wire logic [NW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [NW-1:0] q_in,
    output logic      [NW-1:0] rem_out,
    output logic      [DW-1:0] den_out,
    output logic      [NW-1:0] q_out
);
    logic [NW+DW-1:0] shifted;
    logic             take;

    // compare remainder against den << pos
    always_comb
    begin
        shifted = (NW+DW)'(den_in) << POS;
        take    = (den_in != '0) && ((NW+DW)'(rem_in) >= shifted);
    end

    always_ff @(posedge clk)
    begin
        rem_out <= take ? NW'((NW+DW)'(rem_in) - shifted) : rem_in;
        den_out <= den_in;
        q_out   <= take ? (q_in | (NW'(1) << POS)) : q_in;
    end
endmodule
`default_nettype wire

@@ sim/qrs_checker.sv @@
// beat monitor, root predictor and result comparison for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire qrs_pkg::in_beat_t in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire qrs_pkg::out_beat_t out_data,
    output int                     errors,
    output int                     pending
);
    typedef logic [255:0] wide_t;

    // signed magnitude of a wide term
    typedef struct packed {
        logic  neg;
        wide_t mag;
    } smag_t;

    qrs_pkg::out_beat_t expected_roots[$];

    // floor square root, bit by bit from the top
    function automatic wide_t floor_sqrt(wide_t x);
        wide_t res;
        wide_t trial;
        res = '0;
        for (int i = 127; i >= 0; i--)
        begin
            trial = res | (wide_t'(1) << i);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    // signed sum with tie going to the first operand's sign
    function automatic smag_t smag_add(smag_t p, smag_t q);
        smag_t r;
        if (p.neg == q.neg)
        begin
            r.neg = p.neg;
            r.mag = p.mag + q.mag;
        end
        else if (p.mag >= q.mag)
        begin
            r.neg = p.neg;
            r.mag = p.mag - q.mag;
        end
        else
        begin
            r.neg = q.neg;
            r.mag = q.mag - p.mag;
        end
        return r;
    endfunction

    // truncating division with clamp to the word range
    function automatic logic [qrs_pkg::WORD_W-1:0] clamp_quot(logic neg, wide_t num,
                                                               wide_t den, inout logic sat);
        wide_t q;
        wide_t top;
        top = wide_t'(1) << (qrs_pkg::WORD_W - 1);
        q = num / den;
        if (!neg)
        begin
            if (q > top - 1)
            begin
                q = top - 1;
                sat = 1'b1;
            end
            return q[qrs_pkg::WORD_W-1:0];
        end
        if (q > top)
        begin
            q = top;
            sat = 1'b1;
        end
        return -q[qrs_pkg::WORD_W-1:0];
    endfunction

    function automatic qrs_pkg::out_beat_t solve_quadratic(qrs_pkg::in_beat_t c);
        qrs_pkg::out_beat_t r;
        logic na, nb, nc, sat;
        wide_t ma, mb, mc, den, bsq, fac, wmask;
        smag_t disc, bterm, rt, n1, n2;
        na = c.coef_a[qrs_pkg::WORD_W-1];
        nb = c.coef_b[qrs_pkg::WORD_W-1];
        nc = c.coef_c[qrs_pkg::WORD_W-1];
        wmask = (wide_t'(1) << qrs_pkg::WORD_W) - 1;
        ma = wide_t'(na ? -c.coef_a : c.coef_a) & wmask;
        mb = wide_t'(nb ? -c.coef_b : c.coef_b) & wmask;
        mc = wide_t'(nc ? -c.coef_c : c.coef_c) & wmask;
        sat = 1'b0;
        r = '0;
        if (ma == 0 && mb == 0 && mc == 0)
            r.case_code = qrs_pkg::CASE_INFINITE;
        else if (ma == 0 && mb == 0)
            r.case_code = qrs_pkg::CASE_CONTRA;
        else if (ma == 0)
        begin
            r.case_code = qrs_pkg::CASE_LINEAR;
            r.root_one = clamp_quot(!nc ^ nb, mc << qrs_pkg::FRAC_W, mb, sat);
        end
        else
        begin
            den = ma << 1;
            bsq = mb * mb;
            fac = (ma * mc) << 2;
            disc = smag_add('{neg: 1'b0, mag: bsq}, '{neg: !(na ^ nc), mag: fac});
            if (disc.neg)
                r.case_code = qrs_pkg::CASE_NEG_DISC;
            else if (disc.mag == 0)
            begin
                r.case_code = qrs_pkg::CASE_DOUBLE;
                r.root_one = clamp_quot(!nb ^ na, mb << qrs_pkg::FRAC_W, den, sat);
                r.root_two = r.root_one;
            end
            else
            begin
                r.case_code = qrs_pkg::CASE_TWO;
                bterm = '{neg: !nb, mag: mb << qrs_pkg::FRAC_W};
                rt = '{neg: 1'b0, mag: floor_sqrt(disc.mag << (2 * qrs_pkg::FRAC_W))};
                n1 = smag_add(bterm, rt);
                rt.neg = 1'b1;
                n2 = smag_add(bterm, rt);
                r.root_one = clamp_quot(n1.neg ^ na, n1.mag, den, sat);
                r.root_two = clamp_quot(n2.neg ^ na, n2.mag, den, sat);
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // predict on each accepted input beat, compare each accepted result beat
    always @(posedge clk)
    begin
        qrs_pkg::out_beat_t want;
        if (rst_n && in_valid && in_ready)
            expected_roots.push_back(solve_quadratic(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_roots.size() == 0)
                report_mismatch("unexpected beat, case", out_data.case_code, -1);
            else
            begin
                want = expected_roots.pop_front();
                if (out_data.case_code !== want.case_code)
                    report_mismatch("case_code", out_data.case_code, want.case_code);
                if (out_data.root_one !== want.root_one)
                    report_mismatch("root_one", out_data.root_one, want.root_one);
                if (out_data.root_two !== want.root_two)
                    report_mismatch("root_two", out_data.root_two, want.root_two);
                if (out_data.saturated !== want.saturated)
                    report_mismatch("saturated", out_data.saturated, want.saturated);
            end
        end
        pending = expected_roots.size();
    end
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// stimulus, stalls and verdict for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 250;
    localparam logic signed [qrs_pkg::WORD_W-1:0] MAX_W = 32'sh7fffffff;
    localparam logic signed [qrs_pkg::WORD_W-1:0] MIN_W = 32'sh80000000;
    localparam logic signed [qrs_pkg::WORD_W-1:0] ONE_Q = 32'sh00010000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    qrs_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_ready;
    qrs_pkg::out_beat_t out_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    logic               in_fire_q;
    logic               out_fire_q;
    logic               no_stall;

    quadratic_root_solver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    qrs_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat acceptance seen at the last rising edge
    always @(posedge clk)
    begin
        in_fire_q  <= in_valid && in_ready;
        out_fire_q <= out_valid && out_ready;
        cycles     <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_stall ? 0 : $urandom_range(0, 13);
    endfunction

    // one input beat, called and returning at a falling edge
    task automatic send_coefs(logic signed [qrs_pkg::WORD_W-1:0] a,
                              logic signed [qrs_pkg::WORD_W-1:0] b,
                              logic signed [qrs_pkg::WORD_W-1:0] c);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= '{coef_a: a, coef_b: b, coef_c: c};
        in_valid <= 1'b1;
        do @(negedge clk); while (!in_fire_q);
    endtask

    function automatic logic signed [qrs_pkg::WORD_W-1:0] small_coef();
        return $signed(32'($urandom_range(0, 2 * 65536 * 8))) - 65536 * 8;
    endfunction

    // result side stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_fire_q);
        end
    end

    initial
    begin
        logic signed [qrs_pkg::WORD_W-1:0] k, m;
        cycles   = 0;
        no_stall = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send_coefs(0, 0, 0);
        send_coefs(0, 0, ONE_Q);
        send_coefs(0, 0, MIN_W);
        send_coefs(0, 2 * ONE_Q, -4 * ONE_Q);
        send_coefs(0, 1, MAX_W);
        send_coefs(0, -1, MAX_W);
        send_coefs(0, MIN_W, MIN_W);
        send_coefs(0, 1, MIN_W);
        send_coefs(ONE_Q, 0, ONE_Q);
        send_coefs(ONE_Q, 2 * ONE_Q, ONE_Q);
        send_coefs(-ONE_Q, 2 * ONE_Q, -ONE_Q);
        send_coefs(1, 32'sh00020000, 32'sh00000001 <<< 15);
        send_coefs(ONE_Q, -3 * ONE_Q, 2 * ONE_Q);
        send_coefs(ONE_Q, 0, -ONE_Q);
        send_coefs(1, MAX_W, 1);
        send_coefs(1, MIN_W, 0);
        send_coefs(MIN_W, MIN_W, MIN_W);
        send_coefs(MAX_W, MAX_W, MAX_W);
        send_coefs(MIN_W, MAX_W, MAX_W);
        send_coefs(MAX_W, MIN_W, MIN_W);
        send_coefs(-1, -1, -1);
        send_coefs(1, 0, MIN_W);

        // random coefficient sets across all cases
        for (int i = 0; i < 430; i++)
        begin
            if (i % 40 == 0)
                no_stall = ($urandom_range(0, 3) == 0);
            if (i == 200)
            begin
                // hold off until the pipe has drained
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            case ($urandom_range(0, 5))
                0: send_coefs($urandom, $urandom, $urandom);
                1: send_coefs(small_coef(), small_coef(), small_coef());
                2: send_coefs(0, ($urandom_range(0, 1) ? small_coef() : $urandom), $urandom);
                3:
                begin
                    // perfect square: a = k, b = 2km, c = k m^2
                    k = $signed(32'($urandom_range(1, 4000))) * ($urandom_range(0, 1) ? 1 : -1);
                    m = $signed(32'($urandom_range(0, 600))) - 300;
                    send_coefs(k, 2 * k * m, k * m * m);
                end
                4: send_coefs($signed(32'($urandom_range(0, 7))) - 3, $urandom, small_coef());
                default: send_coefs(small_coef(), $urandom, $urandom_range(0, 1) ? 0 : $urandom);
            endcase
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
